// ===== rtl/sapr_pkg.sv =====
// Shared types, constants and operation codes of the stepper period retimer.
`default_nettype none
package sapr_pkg;

	localparam int unsigned VEL_FRAC_BITS_DEF = 16;
	localparam int unsigned VEL_W = 56;
	localparam int unsigned SPEED_W = 55;
	localparam int unsigned DELTA_W = 57;
	localparam int unsigned DIVD_W = 64;
	localparam int unsigned DIVS_W = 58;
	localparam int unsigned DIV_CNT_W = 6;
	localparam int unsigned SAFETY_MARGIN = 2;
	localparam int unsigned CFG_ADDR_W = 5;

	localparam logic [30:0] MAX_ACCEL_RST = 31'd131071;
	localparam logic [30:0] MAX_DECEL_RST = 31'd131071;
	localparam logic [30:0] MAX_SPEED_RST = 31'd131071;
	localparam logic [31:0] PRESCALE_RST = 32'd65536;
	localparam logic [31:0] CLOCK_FREQ_RST = 32'd84000000;
	localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		REG_MAX_ACCEL = 3'd0,
		REG_MAX_DECEL = 3'd1,
		REG_MAX_SPEED = 3'd2,
		REG_PRESCALE = 3'd3,
		REG_CLOCK_FREQ = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLAMP,
		OP_MUL_A,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_MUL_VMAX,
		OP_DELTA,
		OP_SUM,
		OP_SAT,
		OP_DIVP_START,
		OP_DIV_STEP,
		OP_PERIOD,
		OP_MUL_LEFT,
		OP_DIVL_START,
		OP_FINAL,
		OP_KEEP,
		OP_DIRECT,
		OP_STEP
	} dp_op_t;

	typedef struct packed {
		logic load;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_step;
		logic speed_zero;
		logic cur_zero;
		logic left_big;
		logic des_zero;
		logic div_last;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/sapr_ctrl.sv =====
// Sequencer of the period retimer: walks the datapath through one transaction.
`default_nettype none
module sapr_ctrl
	import sapr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [15:0] {
		ST_IDLE       = 16'h0001,
		ST_CLAMP      = 16'h0002,
		ST_MUL_A      = 16'h0004,
		ST_MUL_LO     = 16'h0008,
		ST_MUL_HI     = 16'h0010,
		ST_MUL_VMAX   = 16'h0020,
		ST_DELTA      = 16'h0040,
		ST_SUM        = 16'h0080,
		ST_SAT        = 16'h0100,
		ST_PREP       = 16'h0200,
		ST_DIVP       = 16'h0400,
		ST_PERIOD     = 16'h0800,
		ST_RETIME     = 16'h1000,
		ST_DIVL_START = 16'h2000,
		ST_DIVL       = 16'h4000,
		ST_FINISH     = 16'h8000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				if (sts.is_step) begin
					state_d = ST_FINISH;
				end else begin
					cmd.op  = OP_CLAMP;
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				cmd.op  = OP_MUL_A;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.op  = OP_MUL_LO;
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.op  = OP_MUL_HI;
				state_d = ST_MUL_VMAX;
			end
			ST_MUL_VMAX: begin
				cmd.op  = OP_MUL_VMAX;
				state_d = ST_DELTA;
			end
			ST_DELTA: begin
				cmd.op  = OP_DELTA;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.op  = OP_SAT;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				if (sts.speed_zero) begin
					state_d = ST_PERIOD;
				end else begin
					cmd.op  = OP_DIVP_START;
					state_d = ST_DIVP;
				end
			end
			ST_DIVP: begin
				cmd.op = OP_DIV_STEP;
				if (sts.div_last) begin
					state_d = ST_PERIOD;
				end
			end
			ST_PERIOD: begin
				cmd.op  = OP_PERIOD;
				state_d = ST_RETIME;
			end
			ST_RETIME: begin
				if (sts.cur_zero || !sts.left_big || sts.des_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.op  = OP_MUL_LEFT;
					state_d = ST_DIVL_START;
				end
			end
			ST_DIVL_START: begin
				cmd.op  = OP_DIVL_START;
				state_d = ST_DIVL;
			end
			ST_DIVL: begin
				cmd.op = OP_DIV_STEP;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					if (sts.is_step) begin
						cmd.op = OP_STEP;
					end else if (sts.cur_zero) begin
						cmd.op = OP_DIRECT;
					end else if (!sts.left_big) begin
						cmd.op = OP_KEEP;
					end else begin
						cmd.op = OP_FINAL;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sapr_dp.sv =====
// Datapath of the period retimer: velocity state, shared multiplier, serial divider.
`default_nettype none
module sapr_dp
	import sapr_pkg::*;
#(
	parameter int unsigned VEL_FRAC_BITS = VEL_FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_sts_t          sts,
	input  wire logic        in_req_type,
	input  wire logic [31:0] in_acceleration,
	input  wire logic [24:0] in_tick_length,
	input  wire logic [31:0] in_timer_count,
	input  wire logic [30:0] accel_lim,
	input  wire logic [30:0] decel_lim,
	input  wire logic [30:0] speed_lim,
	input  wire logic [31:0] prescale_factor,
	input  wire logic [31:0] clock_freq,
	output logic             program_period,
	output logic [31:0]      period_value,
	output logic             direction,
	output logic             direction_changed,
	output logic [31:0]      target_period
);

	localparam int unsigned SHIFT = 40 - VEL_FRAC_BITS;
	localparam logic [DELTA_W-1:0] DELTA_CAP = {1'b1, {(DELTA_W-1){1'b0}}};
	localparam logic [SPEED_W-1:0] VEL_CAP = {SPEED_W{1'b1}};
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVD_W - 1);

	// architectural state
	logic signed [VEL_W-1:0] vel_q;
	logic [31:0]             des_q, cur_q;

	// transaction and intermediate registers
	logic                    req_q;
	logic [31:0]             acc_q, count_q;
	logic [24:0]             tick_q;
	logic [31:0]             amag_q;
	logic                    aneg_q;
	logic [63:0]             m_q, vm_q, lp_q;
	logic [DELTA_W-1:0]      lo_q, hi_q, delta_q;
	logic [SPEED_W-1:0]      vmax_q, speed_q;
	logic signed [57:0]      sum_q;
	logic                    newfwd_q, dchg_q;
	logic [31:0]             newdes_q, left_q;
	logic [DIVS_W-1:0]       rem_q, den_q;
	logic [DIVD_W-1:0]       quo_q;
	logic [DIV_CNT_W-1:0]    cnt_q;

	logic                    old_fwd;
	logic signed [32:0]      a33, la33, ld33, c33;
	logic [32:0]             cabs;
	logic [31:0]             mul_a, mul_b;
	logic [63:0]             mres;
	logic [88:0]             pfull, psh;
	logic [DELTA_W-1:0]      delta_d;
	logic [87:0]             vext;
	logic [SPEED_W-1:0]      vmax_d;
	logic signed [57:0]      vel58, d58, sum_d, vmx, clamped, cneg;
	logic [57:0]             cmag;
	logic [63:0]             num, divp_dividend;
	logic [DIVS_W:0]         trial, tdiff;
	logic                    ge;
	logic [31:0]             qsat, raw_left, nl, nl2, np;
	logic [32:0]             np33;

	assign old_fwd = !vel_q[VEL_W-1] && (|vel_q);

	// limit acceleration by present direction
	always_comb begin
		a33  = {acc_q[31], acc_q};
		la33 = {2'b00, accel_lim};
		ld33 = {2'b00, decel_lim};
		c33  = a33;
		if (old_fwd) begin
			if (a33 > la33) begin
				c33 = la33;
			end else if (a33 < -ld33) begin
				c33 = -ld33;
			end
		end else begin
			if (a33 < -la33) begin
				c33 = -la33;
			end else if (a33 > ld33) begin
				c33 = ld33;
			end
		end
		cabs = c33[32] ? 33'(-c33) : 33'(c33);
	end

	// single shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_A: begin
				mul_a = amag_q;
				mul_b = prescale_factor;
			end
			OP_MUL_LO: begin
				mul_a = m_q[31:0];
				mul_b = {7'b0, tick_q};
			end
			OP_MUL_HI: begin
				mul_a = m_q[63:32];
				mul_b = {7'b0, tick_q};
			end
			OP_MUL_VMAX: begin
				mul_a = {1'b0, speed_lim};
				mul_b = prescale_factor;
			end
			OP_MUL_LEFT: begin
				mul_a = left_q;
				mul_b = newdes_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mres = mul_a * mul_b;
	end

	always_comb begin
		pfull   = {hi_q, 32'b0} + {32'b0, lo_q};
		psh     = pfull >> SHIFT;
		delta_d = (psh > {32'b0, DELTA_CAP}) ? DELTA_CAP : psh[DELTA_W-1:0];

		vext    = ({24'b0, vm_q} << VEL_FRAC_BITS) >> 16;
		vmax_d  = (vext > {33'b0, VEL_CAP}) ? VEL_CAP : vext[SPEED_W-1:0];

		vel58   = {{2{vel_q[VEL_W-1]}}, vel_q};
		d58     = {1'b0, delta_q};
		sum_d   = aneg_q ? (vel58 - d58) : (vel58 + d58);

		vmx     = {3'b0, vmax_q};
		cneg    = -vmx;
		if (sum_q > vmx) begin
			clamped = vmx;
		end else if (sum_q < cneg) begin
			clamped = cneg;
		end else begin
			clamped = sum_q;
		end
		cmag    = clamped[57] ? 58'(-clamped) : 58'(clamped);

		num           = {32'b0, clock_freq} << VEL_FRAC_BITS;
		divp_dividend = {num[62:0], 1'b0} + {9'b0, speed_q};

		trial = {rem_q, quo_q[DIVD_W-1]};
		tdiff = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});

		qsat     = (|quo_q[63:32]) ? ALL_ONES32 : quo_q[31:0];
		raw_left = cur_q - count_q;
		nl       = (des_q == 32'd0) ? ALL_ONES32 : qsat;
		nl2      = (nl < 32'(SAFETY_MARGIN)) ? 32'(SAFETY_MARGIN) : nl;
		np33     = {1'b0, count_q} + {1'b0, nl2};
		np       = np33[32] ? ALL_ONES32 : np33[31:0];
	end

	assign sts.is_step    = req_q;
	assign sts.speed_zero = (speed_q == '0);
	assign sts.cur_zero   = (cur_q == 32'd0);
	assign sts.left_big   = (raw_left > 32'(SAFETY_MARGIN));
	assign sts.des_zero   = (des_q == 32'd0);
	assign sts.div_last   = (cnt_q == DIV_LAST);

	// velocity and period state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q <= '0;
			des_q <= '0;
			cur_q <= '0;
		end else begin
			case (cmd.op)
				OP_SAT: begin
					vel_q <= clamped[VEL_W-1:0];
				end
				OP_FINAL: begin
					des_q <= newdes_q;
					if (nl != left_q) begin
						cur_q <= np;
					end
				end
				OP_KEEP: begin
					des_q <= newdes_q;
				end
				OP_DIRECT: begin
					des_q <= newdes_q;
					cur_q <= newdes_q;
				end
				OP_STEP: begin
					if (des_q != 32'd0) begin
						cur_q <= des_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= in_req_type;
			acc_q   <= in_acceleration;
			tick_q  <= in_tick_length;
			count_q <= in_timer_count;
		end
		case (cmd.op)
			OP_CLAMP: begin
				amag_q <= cabs[31:0];
				aneg_q <= c33[32];
			end
			OP_MUL_A:    m_q  <= mres;
			OP_MUL_LO:   lo_q <= mres[DELTA_W-1:0];
			OP_MUL_HI:   hi_q <= mres[DELTA_W-1:0];
			OP_MUL_VMAX: vm_q <= mres;
			OP_DELTA:    delta_q <= delta_d;
			OP_SUM: begin
				sum_q    <= sum_d;
				vmax_q   <= vmax_d;
				newfwd_q <= !sum_d[57] && (|sum_d);
			end
			OP_SAT: begin
				speed_q <= cmag[SPEED_W-1:0];
				dchg_q  <= old_fwd ^ newfwd_q;
			end
			OP_DIVP_START: begin
				rem_q <= '0;
				quo_q <= divp_dividend;
				den_q <= {2'b0, speed_q, 1'b0};
				cnt_q <= '0;
			end
			OP_DIVL_START: begin
				rem_q <= '0;
				quo_q <= lp_q;
				den_q <= {26'b0, des_q};
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? tdiff[DIVS_W-1:0] : trial[DIVS_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_PERIOD: begin
				newdes_q <= (speed_q == '0) ? ALL_ONES32 : qsat;
				left_q   <= dchg_q ? des_q : raw_left;
			end
			OP_MUL_LEFT: lp_q <= mres;
			OP_FINAL: begin
				program_period    <= (nl != left_q);
				period_value      <= (nl != left_q) ? np : 32'd0;
				direction         <= newfwd_q;
				direction_changed <= dchg_q;
				target_period     <= newdes_q;
			end
			OP_KEEP: begin
				program_period    <= 1'b0;
				period_value      <= 32'd0;
				direction         <= newfwd_q;
				direction_changed <= dchg_q;
				target_period     <= newdes_q;
			end
			OP_DIRECT: begin
				program_period    <= 1'b1;
				period_value      <= newdes_q;
				direction         <= newfwd_q;
				direction_changed <= dchg_q;
				target_period     <= newdes_q;
			end
			OP_STEP: begin
				program_period    <= (des_q != 32'd0);
				period_value      <= des_q;
				direction         <= old_fwd;
				direction_changed <= 1'b0;
				target_period     <= des_q;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/stepper_accel_period_retimer_unit.sv =====
// Top level of the stepper velocity integrator and step period retimer.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-------------------------------------------
//  in       | sink      | in_valid/in_stall  | req_type, acceleration, tick_length,
//           |           |                    | timer_count
//  out      | source    | out_valid/out_stall| program_period, period_value, direction,
//           |           |                    | direction_changed, target_period
//  apb      | slave     | psel/penable       | five limit and scaling registers
//
// A step event goes from acceptance through the clamp state to the finish state. A
// control tick walks the clamp, multiply, delta, sum and saturate states, then one pass
// of the one-bit-per-cycle restoring divider for the period (skipped at zero speed) and,
// when the step in progress is rescaled, one more multiply and a second divider pass.
// Reset clears the velocity, both periods, the sequencer and the output valid; the
// registers return to their defaults. One transaction is worked on at a time; a held
// result waits in the output register, and the next transaction is accepted meanwhile
// and holds in the last sequencer state until the output register frees.
`default_nettype none
module stepper_accel_period_retimer_unit
	import sapr_pkg::*;
#(
	parameter int unsigned VEL_FRAC_BITS = VEL_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input transaction
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  req_type,
	input  wire logic [31:0]           acceleration,
	input  wire logic [24:0]           tick_length,
	input  wire logic [31:0]           timer_count,
	// result transaction
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       program_period,
	output logic [31:0]                period_value,
	output logic                       direction,
	output logic                       direction_changed,
	output logic [31:0]                target_period,
	// register port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic [30:0] accel_lim_q, decel_lim_q, speed_lim_q;
	logic [31:0] prescale_q, clock_freq_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	// register file: write on the access phase, index by word address
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_lim_q  <= MAX_ACCEL_RST;
			decel_lim_q  <= MAX_DECEL_RST;
			speed_lim_q  <= MAX_SPEED_RST;
			prescale_q   <= PRESCALE_RST;
			clock_freq_q <= CLOCK_FREQ_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MAX_ACCEL:  accel_lim_q  <= pwdata[30:0];
				REG_MAX_DECEL:  decel_lim_q  <= pwdata[30:0];
				REG_MAX_SPEED:  speed_lim_q  <= pwdata[30:0];
				REG_PRESCALE:   prescale_q   <= pwdata;
				REG_CLOCK_FREQ: clock_freq_q <= pwdata;
				default: begin
					// drop writes past the last register
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MAX_ACCEL:  prdata = {1'b0, accel_lim_q};
			REG_MAX_DECEL:  prdata = {1'b0, decel_lim_q};
			REG_MAX_SPEED:  prdata = {1'b0, speed_lim_q};
			REG_PRESCALE:   prdata = prescale_q;
			REG_CLOCK_FREQ: prdata = clock_freq_q;
			default:        prdata = 32'd0;
		endcase
	end

	// sequencer: accept, step the datapath, hand off to the output register
	sapr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: clamp, integrate, saturate, divide, retime
	sapr_dp #(
		.VEL_FRAC_BITS (VEL_FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_req_type       (req_type),
		.in_acceleration   (acceleration),
		.in_tick_length    (tick_length),
		.in_timer_count    (timer_count),
		.accel_lim         (accel_lim_q),
		.decel_lim         (decel_lim_q),
		.speed_lim         (speed_lim_q),
		.prescale_factor   (prescale_q),
		.clock_freq        (clock_freq_q),
		.program_period    (program_period),
		.period_value      (period_value),
		.direction         (direction),
		.direction_changed (direction_changed),
		.target_period     (target_period)
	);

endmodule
`default_nettype wire
